### hdl/text_console_writer_assert.svh
// Assertion macros for the text console writer checker.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tcw_pkg.sv
package tcw_pkg;

	localparam int CODE_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;

	localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
	localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;

	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
	localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_FILL,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		SW_INIT,
		SW_FILL,
		SW_SCROLL
	} sweep_mode_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [CODE_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_pos;
		logic [CELL_W-1:0] cell_data;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic        accept;
		logic        sweep_load;
		logic        sweep_step;
		sweep_mode_t mode;
		logic        load_rsp;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic scroll_req;
		logic sweep_last;
		logic rsp_free;
	} sts_t;

endpackage

### hdl/tcw_ram.sv
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hdl/tcw_ctrl.sv
module tcw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  logic [1:0]    req_cmd,
	input  tcw_pkg::sts_t sts,
	output tcw_pkg::ctl_t ctl
);

	import tcw_pkg::*;

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		req_ready = 1'b0;
		ctl       = '0;
		ctl.mode  = SW_INIT;
		case (state_q)
			ST_INIT: begin
				ctl.sweep_step = 1'b1;
				ctl.mode       = SW_INIT;
				if (sts.sweep_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.accept = 1'b1;
					case (cmd_t'(req_cmd))
						CMD_PUT: begin
							if (sts.scroll_req) begin
								ctl.sweep_load = 1'b1;
								ctl.mode       = SW_SCROLL;
								state_n        = ST_SCROLL;
							end else begin
								state_n = ST_FINISH;
							end
						end
						CMD_CLEAR: begin
							ctl.sweep_load = 1'b1;
							ctl.mode       = SW_FILL;
							state_n        = ST_FILL;
						end
						default: begin
							state_n = ST_FINISH;
						end
					endcase
				end
			end
			ST_SCROLL: begin
				ctl.sweep_step = 1'b1;
				ctl.mode       = SW_SCROLL;
				if (sts.sweep_last) begin
					state_n = ST_FINISH;
				end
			end
			ST_FILL: begin
				ctl.sweep_step = 1'b1;
				ctl.mode       = SW_FILL;
				if (sts.sweep_last) begin
					state_n = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.rsp_free) begin
					ctl.load_rsp = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_INIT;
			end
		endcase
	end

endmodule

### hdl/tcw_dp.sv
module tcw_dp #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcw_pkg::req_t                req,
	input  logic                         cfg_valid,
	input  logic [tcw_pkg::ATTR_W-1:0]   cfg_data,
	input  tcw_pkg::ctl_t                ctl,
	output tcw_pkg::sts_t                sts,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output tcw_pkg::rsp_t                rsp
);

	import tcw_pkg::*;

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SW_W   = $clog2(CELLS + COLUMNS);
	localparam int CW     = $clog2(COLUMNS);
	localparam int CIW    = CW + 1;
	localparam int TW     = $clog2(COLUMNS + TAB_STOP);
	localparam int RW     = $clog2(ROWS);
	localparam int PW     = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
	localparam int XW     = (SW_W > IDX_W) ? SW_W : IDX_W;
	localparam int PXW    = (ADDR_W > POS_W) ? ADDR_W : POS_W;
	// column phase after subtracting the line width once or twice from a tab stop
	localparam int WRAP1  = (TAB_STOP - (COLUMNS % TAB_STOP)) % TAB_STOP;
	localparam int WRAP2  = (TAB_STOP - ((2 * COLUMNS) % TAB_STOP)) % TAB_STOP;

	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [PW-1:0]     ph_q;
	logic [ATTR_W-1:0] attr_q;
	logic [SW_W-1:0]   sweep_q;
	logic              copy_s1;
	logic              from_mem_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              rd_hit_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [CIW-1:0]    col_inc;
	logic [TW-1:0]     tab_sum;
	logic [TW-1:0]     tab_t;
	logic [TW-1:0]     tab_t1;
	logic [TW-1:0]     tab_t2;
	logic              tab_k1;
	logic              tab_k2;
	logic [PW-1:0]     ph_inc;
	logic [PW-1:0]     ph_dec;
	logic [ADDR_W-1:0] base_addr;
	logic [CW-1:0]     col_n;
	logic [RW-1:0]     row_n;
	logic [PW-1:0]     ph_n;
	logic              row_adv;
	logic              row_last;
	logic              put_wr;
	logic [ADDR_W-1:0] put_addr;
	logic [CELL_W-1:0] put_data;
	logic [CELL_W-1:0] blank;
	logic              is_put;
	logic              is_read;
	logic [XW-1:0]     idx_x;
	logic              idx_hit;
	logic              sweep_in;
	logic [SW_W-1:0]   sweep_back;
	logic [PXW-1:0]    pos_x;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [CELL_W-1:0] wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [CELL_W-1:0] rd_data;

	assign blank   = {attr_q, CH_SPACE};
	assign is_put  = (cmd_t'(req.cmd) == CMD_PUT);
	assign is_read = (cmd_t'(req.cmd) == CMD_READ);
	assign idx_x   = XW'(req.cell_index);
	assign idx_hit = (idx_x < XW'(CELLS));

	// cursor update for one put request
	always_comb begin
		col_inc   = {1'b0, col_q} + CIW'(1);
		tab_sum   = TW'(col_q) + TW'(TAB_STOP);
		tab_t     = tab_sum - TW'(ph_q);
		tab_k1    = (tab_t >= TW'(COLUMNS));
		tab_t1    = tab_k1 ? (tab_t - TW'(COLUMNS)) : tab_t;
		tab_k2    = (tab_t1 >= TW'(COLUMNS));
		tab_t2    = tab_k2 ? (tab_t1 - TW'(COLUMNS)) : tab_t1;
		ph_inc    = (ph_q == PW'(TAB_STOP - 1)) ? '0 : ph_q + PW'(1);
		ph_dec    = (ph_q == '0) ? PW'(TAB_STOP - 1) : ph_q - PW'(1);
		base_addr = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);

		col_n    = col_q;
		ph_n     = ph_q;
		row_adv  = 1'b0;
		put_wr   = 1'b0;
		put_addr = base_addr;
		put_data = {attr_q, req.char_code};
		case (req.char_code)
			CH_BS: begin
				if (col_q != '0) begin
					col_n    = col_q - CW'(1);
					ph_n     = ph_dec;
					put_wr   = 1'b1;
					put_addr = base_addr - ADDR_W'(1);
					put_data = blank;
				end
			end
			CH_TAB: begin
				row_adv = (tab_sum >= TW'(COLUMNS));
				col_n   = CW'(tab_t2);
				ph_n    = tab_k2 ? PW'(WRAP2) : (tab_k1 ? PW'(WRAP1) : '0);
			end
			CH_CR: begin
				col_n = '0;
				ph_n  = '0;
			end
			CH_LF: begin
				col_n   = '0;
				ph_n    = '0;
				row_adv = 1'b1;
			end
			default: begin
				if (req.char_code >= CH_SPACE) begin
					put_wr = 1'b1;
					if (col_inc == CIW'(COLUMNS)) begin
						col_n   = '0;
						ph_n    = '0;
						row_adv = 1'b1;
					end else begin
						col_n = col_inc[CW-1:0];
						ph_n  = ph_inc;
					end
				end
			end
		endcase
		row_last = (row_q == RW'(ROWS - 1));
		row_n    = (row_adv && !row_last) ? row_q + RW'(1) : row_q;
	end

	assign sts.scroll_req = is_put && row_adv && row_last;
	assign sts.sweep_last = (ctl.mode == SW_SCROLL) ? (sweep_q == SW_W'(CELLS + COLUMNS - 1))
	                                                : (sweep_q == SW_W'(CELLS - 1));
	assign sts.rsp_free   = !rsp_valid_q || rsp_ready;

	assign sweep_in   = (sweep_q < SW_W'(CELLS));
	assign sweep_back = sweep_q - SW_W'(COLUMNS);

	// memory port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = put_addr;
		wr_data = put_data;
		if (copy_s1) begin
			wr_en   = 1'b1;
			wr_addr = addr_s1;
			wr_data = from_mem_s1 ? rd_data : blank;
		end else if (ctl.sweep_step && (ctl.mode == SW_INIT)) begin
			wr_en   = 1'b1;
			wr_addr = sweep_q[ADDR_W-1:0];
			wr_data = RESET_CELL;
		end else if (ctl.sweep_step && (ctl.mode == SW_FILL)) begin
			wr_en   = 1'b1;
			wr_addr = sweep_q[ADDR_W-1:0];
			wr_data = blank;
		end else if (ctl.accept && is_put) begin
			wr_en = put_wr;
		end

		rd_en   = 1'b0;
		rd_addr = idx_x[ADDR_W-1:0];
		if (ctl.sweep_step && (ctl.mode == SW_SCROLL)) begin
			rd_en   = sweep_in;
			rd_addr = sweep_q[ADDR_W-1:0];
		end else if (ctl.accept && is_read) begin
			rd_en = idx_hit;
		end
	end

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			ph_q        <= '0;
			attr_q      <= RESET_ATTR;
			sweep_q     <= '0;
			copy_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				attr_q <= cfg_data;
			end
			if (ctl.accept) begin
				case (cmd_t'(req.cmd))
					CMD_PUT: begin
						col_q <= col_n;
						row_q <= row_n;
						ph_q  <= ph_n;
					end
					CMD_CLEAR: begin
						col_q <= '0;
						row_q <= '0;
						ph_q  <= '0;
					end
					default: begin
						col_q <= col_q;
					end
				endcase
			end
			if (ctl.sweep_load) begin
				sweep_q <= (ctl.mode == SW_SCROLL) ? SW_W'(COLUMNS) : '0;
			end else if (ctl.sweep_step) begin
				sweep_q <= sweep_q + SW_W'(1);
			end
			copy_s1 <= ctl.sweep_step && (ctl.mode == SW_SCROLL);
			if (ctl.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign pos_x = PXW'(base_addr);

	always_ff @(posedge clk) begin
		from_mem_s1 <= sweep_in;
		addr_s1     <= sweep_back[ADDR_W-1:0];
		if (ctl.accept) begin
			rd_hit_q <= is_read && idx_hit;
		end
		if (ctl.load_rsp) begin
			rsp_q.cursor_pos <= pos_x[POS_W-1:0];
			rsp_q.cell_data  <= rd_hit_q ? rd_data : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### hdl/text_console_writer.sv
// Put and read: the request is taken in idle, and the response is loaded into the output
// register once that register is free; a new request is taken only after that. A put that
// scrolls and a clear run a sweep over the store, paced by the single write port of the cell
// store, which moves or blanks one cell per cycle. Reset: asynchronous, active low; the cursor
// homes and attribute reads 0x0F, then a clearing pass blanks the store with req_ready low.
// Configuration writes are taken in every cycle, also during that pass.
module text_console_writer #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel: command, character code and cell index
	input  logic                       req_valid,
	output logic                       req_ready,
	input  tcw_pkg::req_t              req,
	// response channel: cursor position and read cell
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output tcw_pkg::rsp_t              rsp,
	// attribute register write
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tcw_pkg::ATTR_W-1:0] cfg_data
);

	import tcw_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// The attribute register takes a write in any cycle; the user must write it only while idle,
	// so an in-flight request never sees it change. The block itself does not enforce this.
	assign cfg_ready = 1'b1;

	// Controller: sequences the reset clearing pass, accepts one request at a time in
	// idle, runs the scroll or clear sweep when one is needed, and hands the response to
	// the output register once that register is free. Hold the request channel closed
	// whenever it is not idle.
	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_cmd   (req.cmd),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Datapath: cursor and tab-phase registers, attribute register, the cell store and
	// its sweep counter, and the response register. A put writes its cell on the edge
	// that takes the request; a scroll then copies each row up by one, reading one cell
	// ahead of the write it feeds, and blanks the bottom row with the same pass.
	tcw_dp #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

### hdl/tcw_checker.sv
`include "text_console_writer_assert.svh"

module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input tcw_pkg::rsp_t rsp
);

	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;

	logic [1:0] pending_q;
	logic       req_take;
	logic       rsp_take;

	assign req_take = req_valid && req_ready;
	assign rsp_take = rsp_valid && rsp_ready;

	// count requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, req_take} - {1'b0, rsp_take};
		end
	end

	`TCW_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response dropped or changed while stalled")
	`TCW_ASSERT_IMPLY(a_rsp_has_req, clk, arst_n, rsp_valid, pending_q != 2'd0, "response without a pending request")
	`TCW_ASSERT_IMPLY(a_no_third, clk, arst_n, pending_q == 2'd2, !req_ready, "request taken with one in flight and one waiting")
	`TCW_ASSERT_IMPLY(a_pos_range, clk, arst_n, rsp_valid, 32'(rsp.cursor_pos) < CELLS, "cursor position outside the screen")

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
